### rtl/hrrc_pkg.sv
// Types and constants shared by the heater reset relay controller.
// No dependencies; the top level imports this package.
`default_nettype none

package hrrc_pkg;

    // Item selector codes
    localparam logic [1:0] FUNC_EVAL    = 2'd0;
    localparam logic [1:0] FUNC_FORCE   = 2'd1;
    localparam logic [1:0] FUNC_UNFORCE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CURRENT_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_PULSE_SEC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_SWITCH_SEC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE_MIN_SEC  = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic signed [7:0] RST_TEMP_THRESHOLD     = 8'sd18;
    localparam logic [11:0]       RST_ACTIVE_CURRENT_MIN = 12'd10;
    localparam logic [15:0]       RST_RESET_PULSE_SEC    = 16'd10;
    localparam logic [15:0]       RST_SAFE_SWITCH_SEC    = 16'd300;
    localparam logic [15:0]       RST_INACTIVE_MIN_SEC   = 16'd900;

    // Sensor code for an unknown room temperature
    localparam logic signed [7:0] UNKNOWN_TEMP = -8'sd127;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        now_sec;
        logic signed [7:0]  room_temp;
        logic [11:0]        heater_centiamps;
        logic               force_state;
        logic [31:0]        force_until;
    } t_in_item;

    typedef struct packed {
        logic        relay_active;
        logic        forced_mode;
        logic        permanent_mode;
        logic        switched;
        logic [31:0] switch_time;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/heater_reset_relay_controller_top.sv
// Heater reset relay controller: input register, decision logic, result register.
// Depends on hrrc_pkg for the transaction structs, selector codes and register indexes.
`default_nettype none

// Takes one transaction per clock with no gaps while the output is not
// stalled: an item sits in the input register while the decision logic (two
// 32-bit absolute time differences and their compares) runs, and its result
// is loaded into the output register at the edge on which that register is
// free or being taken. The relay state is updated at that same edge, so the
// following item is evaluated against it. The configuration port is always ready.
module heater_reset_relay_controller_top
    import hrrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_item                  o_out_item,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    // Configuration registers
    logic signed [7:0] r_temp_threshold;
    logic [11:0]       r_active_current_min;
    logic [15:0]       r_reset_pulse_sec;
    logic [15:0]       r_safe_switch_sec;
    logic [15:0]       r_inactive_min_sec;

    // Controller state
    logic        r_relay_on, n_relay_on;
    logic        r_forced, n_forced;
    logic        r_forced_perm, n_forced_perm;
    logic [31:0] r_last_switch, n_last_switch;
    logic [31:0] r_force_end, n_force_end;
    logic [31:0] r_last_active, n_last_active;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic adv;
    logic load_in;
    logic w_sw;

    logic        active;
    logic        override_live;
    logic [31:0] d_switch;
    logic [31:0] d_active;
    logic        pulse_done;
    logic        safe_ok;
    logic        idle_ok;
    logic        temp_ok;

    // Handshake control
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign load_in    = !r_in_valid || adv;
    assign o_in_stall = !load_in;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Time differences and compares
    assign active        = r_in.heater_centiamps >= r_active_current_min;
    assign override_live = r_forced && ((r_force_end == 32'd0) || (r_in.now_sec < r_force_end));
    assign d_switch = (r_in.now_sec < r_last_switch) ? (r_last_switch - r_in.now_sec)
                                                     : (r_in.now_sec - r_last_switch);
    assign d_active = (r_in.now_sec < r_last_active) ? (r_last_active - r_in.now_sec)
                                                     : (r_in.now_sec - r_last_active);
    assign pulse_done = d_switch >= {16'd0, r_reset_pulse_sec};
    assign safe_ok    = d_switch >= {16'd0, r_safe_switch_sec};
    assign idle_ok    = d_active >= {16'd0, r_inactive_min_sec};
    assign temp_ok    = (r_in.room_temp != UNKNOWN_TEMP) && (r_in.room_temp <= r_temp_threshold);

    // Next state for the item in the input register
    always_comb begin
        n_relay_on    = r_relay_on;
        n_forced      = r_forced;
        n_forced_perm = r_forced_perm;
        n_last_switch = r_last_switch;
        n_force_end   = r_force_end;
        n_last_active = r_last_active;
        w_sw          = 1'b0;
        case (r_in.func)
            FUNC_EVAL: begin
                if (active) begin
                    n_last_active = r_in.now_sec;
                end
                if (!override_live) begin
                    n_forced = 1'b0;
                    // End a running pulse, or start one when conditions allow
                    if (r_relay_on) begin
                        w_sw = pulse_done;
                    end else begin
                        w_sw = safe_ok && temp_ok && !active && idle_ok;
                    end
                end
            end
            FUNC_FORCE: begin
                n_forced      = 1'b1;
                n_forced_perm = (r_in.force_until == 32'd0);
                n_force_end   = r_in.force_until;
                w_sw          = (r_relay_on != r_in.force_state);
            end
            FUNC_UNFORCE: begin
                n_forced      = 1'b0;
                n_forced_perm = 1'b0;
            end
            default: begin
            end
        endcase
        if (w_sw) begin
            n_relay_on    = !r_relay_on;
            n_last_switch = r_in.now_sec;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_threshold     <= RST_TEMP_THRESHOLD;
            r_active_current_min <= RST_ACTIVE_CURRENT_MIN;
            r_reset_pulse_sec    <= RST_RESET_PULSE_SEC;
            r_safe_switch_sec    <= RST_SAFE_SWITCH_SEC;
            r_inactive_min_sec   <= RST_INACTIVE_MIN_SEC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEMP_THRESHOLD:     r_temp_threshold     <= i_cfg_data[7:0];
                CFG_ACTIVE_CURRENT_MIN: r_active_current_min <= i_cfg_data[11:0];
                CFG_RESET_PULSE_SEC:    r_reset_pulse_sec    <= i_cfg_data;
                CFG_SAFE_SWITCH_SEC:    r_safe_switch_sec    <= i_cfg_data;
                CFG_INACTIVE_MIN_SEC:   r_inactive_min_sec   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: load a new transaction whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
        if (load_in && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Controller state and result register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_on    <= 1'b0;
            r_forced      <= 1'b0;
            r_forced_perm <= 1'b0;
            r_last_switch <= 32'd0;
            r_force_end   <= 32'd0;
            r_last_active <= 32'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (adv) begin
                r_relay_on    <= n_relay_on;
                r_forced      <= n_forced;
                r_forced_perm <= n_forced_perm;
                r_last_switch <= n_last_switch;
                r_force_end   <= n_force_end;
                r_last_active <= n_last_active;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
        if (adv) begin
            r_out.relay_active   <= n_relay_on;
            r_out.forced_mode    <= n_forced;
            r_out.permanent_mode <= n_forced_perm;
            r_out.switched       <= w_sw;
            r_out.switch_time    <= n_last_switch;
        end
    end

`ifndef NO_ASSERTIONS
    // A permanent override is always an override in effect
    a_perm_implies_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_forced_perm |-> r_forced)
        else $error("permanent override without override");

    // A reported switch flips the stored relay state
    a_switch_flips_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && w_sw) |=> (r_relay_on != $past(r_relay_on)))
        else $error("switch reported but relay state unchanged");

    // A held item in the input register is not dropped
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input transaction dropped while blocked");

    // No state change without a transaction moving to the result register
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_relay_on) && $stable(r_last_switch))
        else $error("relay state changed without a transaction");
`endif

endmodule

`default_nettype wire
